// ===== hdl/assert_macros.svh =====
// Assertion helpers for the grid walker top level.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// An antecedent that holds at a clock edge requires the consequent at the same edge.
`define MAGA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// A condition that must hold at every clock edge outside reset.
`define MAGA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define MAGA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MAGA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/maga_pkg.sv =====
package maga_pkg;

   // Field widths of the request and response words.
   localparam int CMD_W    = 2;
   localparam int POS_W    = 8;
   localparam int ARG_W    = 2;
   localparam int IDX_W    = 4;
   localparam int SIZE_W   = 9;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_STEP = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_HALT    = 2'd3;

   // Headings and turn offsets.
   localparam logic [1:0] HEAD_UP    = 2'd0;
   localparam logic [1:0] HEAD_RIGHT = 2'd1;
   localparam logic [1:0] HEAD_DOWN  = 2'd2;
   localparam logic [1:0] HEAD_LEFT  = 2'd3;
   localparam logic [1:0] TURN_LEFT  = 2'd3;
   localparam logic [1:0] TURN_RIGHT = 2'd1;

   // Configuration register indexes and reset value.
   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 1'b1;
   localparam logic [SIZE_W-1:0]    CFG_RESET = 9'd16;

   // Which response the datapath builds when it loads the output register.
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_INIT = 3'd0;
   localparam kind_type KIND_SET  = 3'd1;
   localparam kind_type KIND_ADD  = 3'd2;
   localparam kind_type KIND_NONE = 3'd3;
   localparam kind_type KIND_ANT  = 3'd4;

   // Source of the board read row address.
   typedef logic [1:0] rdsel_type;
   localparam rdsel_type RD_ANT = 2'd0;
   localparam rdsel_type RD_CUR = 2'd1;
   localparam rdsel_type RD_SET = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      capture;
      logic      init_win;
      logic      clr_step;
      logic      board_rd;
      rdsel_type rd_sel;
      logic      set_wr;
      logic      add_ant;
      logic      step_first;
      logic      step_next;
      logic      ant_rd;
      logic      ant_load;
      logic      flip_move;
      logic      turn;
      logic      load_out;
      kind_type  out_kind;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic out_free;
      logic halted;
      logic no_ants;
      logic last_ant;
   } ctl_sts_type;

endpackage

// ===== hdl/maga_req_if.sv =====
interface maga_req_if;
   logic                        valid;
   logic                        ready;
   logic [maga_pkg::CMD_W-1:0]  cmd;
   logic [maga_pkg::POS_W-1:0]  row_in;
   logic [maga_pkg::POS_W-1:0]  col_in;
   logic [maga_pkg::ARG_W-1:0]  arg;

   modport source (output valid, output cmd, output row_in, output col_in, output arg,
                   input ready);
   modport sink (input valid, input cmd, input row_in, input col_in, input arg,
                 output ready);
endinterface

// ===== hdl/maga_rsp_if.sv =====
interface maga_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [maga_pkg::IDX_W-1:0]     ant_index;
   logic [maga_pkg::POS_W-1:0]     ant_row;
   logic [maga_pkg::POS_W-1:0]     ant_col;
   logic [1:0]                     heading;
   logic [maga_pkg::SIZE_W-1:0]    window_rows;
   logic [maga_pkg::SIZE_W-1:0]    window_cols;
   logic [maga_pkg::STATUS_W-1:0]  status;
   logic                           last;

   modport source (output valid, output ant_index, output ant_row, output ant_col,
                   output heading, output window_rows, output window_cols,
                   output status, output last, input ready);
   modport sink (input valid, input ant_index, input ant_row, input ant_col,
                 input heading, input window_rows, input window_cols,
                 input status, input last, output ready);
endinterface

// ===== hdl/maga_datapath.sv =====
module maga_datapath #(
   parameter int BOARD_SIDE = 256,
   parameter int MAX_ANTS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [maga_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [maga_pkg::SIZE_W-1:0]       csr_wdata,
   input  logic [maga_pkg::POS_W-1:0]        req_row_in,
   input  logic [maga_pkg::POS_W-1:0]        req_col_in,
   input  logic [maga_pkg::ARG_W-1:0]        req_arg,
   input  maga_pkg::ctl_cmd_type             cmd_i,
   output maga_pkg::ctl_sts_type             sts_o,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [maga_pkg::IDX_W-1:0]        rsp_ant_index,
   output logic [maga_pkg::POS_W-1:0]        rsp_ant_row,
   output logic [maga_pkg::POS_W-1:0]        rsp_ant_col,
   output logic [1:0]                        rsp_heading,
   output logic [maga_pkg::SIZE_W-1:0]       rsp_window_rows,
   output logic [maga_pkg::SIZE_W-1:0]       rsp_window_cols,
   output logic [maga_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last
);

   localparam int CW = $clog2(BOARD_SIDE);
   localparam int LW = CW + 2;
   localparam int AW = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
   localparam int NW = $clog2(MAX_ANTS + 1);
   localparam int WIN_LIMIT = (BOARD_SIDE < 256) ? BOARD_SIDE : 256;
   localparam logic [9:0] WIN_LIM10 = 10'(WIN_LIMIT);
   localparam logic [maga_pkg::SIZE_W-1:0] WIN_LIM9 = maga_pkg::SIZE_W'(WIN_LIMIT);

   typedef struct packed {
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic [1:0]    head;
   } ant_entry_type;

   // Configuration registers.
   logic [maga_pkg::SIZE_W-1:0] cfg_rows_ff, cfg_rows_in;
   logic [maga_pkg::SIZE_W-1:0] cfg_cols_ff, cfg_cols_in;

   // Captured request word.
   logic [maga_pkg::POS_W-1:0] req_row_ff, req_row_in_nx;
   logic [maga_pkg::POS_W-1:0] req_col_ff, req_col_in_nx;
   logic [maga_pkg::ARG_W-1:0] req_arg_ff, req_arg_in;

   // Window, ant count and halt flag.
   logic [CW-1:0]               top_ff, top_in;
   logic [CW-1:0]               left_ff, left_in;
   logic [maga_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [maga_pkg::SIZE_W-1:0] width_ff, width_in;
   logic                        halted_ff, halted_in;
   logic [NW-1:0]               count_ff, count_in;

   // Clearing pass row counter and step walk state.
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] step_idx_ff, step_idx_in;
   logic [CW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [1:0]    cur_head_ff, cur_head_in;

   // Memories and their registered read data.
   logic [BOARD_SIDE-1:0] board_mem [BOARD_SIDE];
   logic [BOARD_SIDE-1:0] board_rd_ff;
   ant_entry_type         ant_mem [MAX_ANTS];
   ant_entry_type         ant_rd_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [maga_pkg::IDX_W-1:0]    out_idx_ff, res_idx;
   logic [maga_pkg::POS_W-1:0]    out_row_ff, res_row;
   logic [maga_pkg::POS_W-1:0]    out_col_ff, res_col;
   logic [1:0]                    out_head_ff, res_head;
   logic [maga_pkg::SIZE_W-1:0]   out_wrows_ff, out_wcols_ff;
   logic [maga_pkg::STATUS_W-1:0] out_status_ff, res_status;
   logic                          out_last_ff, res_last;

   // Derived values.
   logic [maga_pkg::SIZE_W-1:0] rows_cl, cols_cl;
   logic [CW-1:0]               init_top, init_left;
   logic                        set_inside, ant_full, add_ok;
   logic [CW-1:0]               set_row_abs, set_col_abs;
   logic [CW-1:0]               rel_row, rel_col;
   logic [maga_pkg::SIZE_W-1:0] rel_row9, rel_col9;
   logic [9:0]                  h_dbl, w_dbl;
   logic                        can_up, can_down, can_left, can_right;
   logic                        leave, grow_ok, move_ok;
   logic [CW-1:0]               new_row, new_col;
   logic [1:0]                  head_turned;
   logic                        clr_last, last_ant;
   logic [BOARD_SIDE-1:0]       set_mask, flip_mask;
   logic                        board_we;
   logic [CW-1:0]               board_wa, board_ra;
   logic [BOARD_SIDE-1:0]       board_wd;
   logic                        ant_we;
   logic [AW-1:0]               ant_wa;
   ant_entry_type               ant_wd;

   // Window size and placement chosen by the init command.
   always_comb begin
      if (cfg_rows_ff == '0) begin
         rows_cl = maga_pkg::SIZE_W'(1);
      end else if (cfg_rows_ff > WIN_LIM9) begin
         rows_cl = WIN_LIM9;
      end else begin
         rows_cl = cfg_rows_ff;
      end
      if (cfg_cols_ff == '0) begin
         cols_cl = maga_pkg::SIZE_W'(1);
      end else if (cfg_cols_ff > WIN_LIM9) begin
         cols_cl = WIN_LIM9;
      end else begin
         cols_cl = cfg_cols_ff;
      end
      init_top  = CW'((LW'(BOARD_SIDE) - LW'(rows_cl)) >> 1);
      init_left = CW'((LW'(BOARD_SIDE) - LW'(cols_cl)) >> 1);
   end

   // Window checks and absolute position for set cell and add ant.
   assign set_inside  = ({1'b0, req_row_ff} < height_ff) && ({1'b0, req_col_ff} < width_ff);
   assign set_row_abs = CW'(LW'(top_ff) + LW'(req_row_ff));
   assign set_col_abs = CW'(LW'(left_ff) + LW'(req_col_ff));
   assign ant_full    = (count_ff >= NW'(MAX_ANTS));
   assign add_ok      = !ant_full && set_inside;

   // Position of the current ant inside the window and the growth checks.
   assign rel_row  = cur_row_ff - top_ff;
   assign rel_col  = cur_col_ff - left_ff;
   assign rel_row9 = maga_pkg::SIZE_W'(rel_row);
   assign rel_col9 = maga_pkg::SIZE_W'(rel_col);
   assign h_dbl    = {height_ff, 1'b0};
   assign w_dbl    = {width_ff, 1'b0};
   assign can_up    = (LW'(top_ff) >= LW'(height_ff)) && (h_dbl <= WIN_LIM10);
   assign can_down  = ((LW'(top_ff) + LW'(h_dbl)) <= LW'(BOARD_SIDE)) && (h_dbl <= WIN_LIM10);
   assign can_left  = (LW'(left_ff) >= LW'(width_ff)) && (w_dbl <= WIN_LIM10);
   assign can_right = ((LW'(left_ff) + LW'(w_dbl)) <= LW'(BOARD_SIDE)) && (w_dbl <= WIN_LIM10);

   // One move along the heading; leave is set when the ant exits the window.
   always_comb begin
      new_row = cur_row_ff;
      new_col = cur_col_ff;
      case (cur_head_ff)
         maga_pkg::HEAD_UP: begin
            new_row = cur_row_ff - 1'b1;
            leave   = (rel_row9 == '0);
            grow_ok = can_up;
         end
         maga_pkg::HEAD_DOWN: begin
            new_row = cur_row_ff + 1'b1;
            leave   = ((10'(rel_row9) + 10'd1) == 10'(height_ff));
            grow_ok = can_down;
         end
         maga_pkg::HEAD_LEFT: begin
            new_col = cur_col_ff - 1'b1;
            leave   = (rel_col9 == '0);
            grow_ok = can_left;
         end
         maga_pkg::HEAD_RIGHT: begin
            new_col = cur_col_ff + 1'b1;
            leave   = ((10'(rel_col9) + 10'd1) == 10'(width_ff));
            grow_ok = can_right;
         end
         default: begin
            leave   = 1'b0;
            grow_ok = 1'b0;
         end
      endcase
      move_ok = !leave || grow_ok;
   end

   // The ant turns left on black and right on white.
   assign head_turned = board_rd_ff[cur_col_ff] ? (cur_head_ff + maga_pkg::TURN_LEFT)
                                                : (cur_head_ff + maga_pkg::TURN_RIGHT);

   assign clr_last = (clr_cnt_ff == CW'(BOARD_SIDE - 1));
   assign last_ant = ((NW'(step_idx_ff) + NW'(1)) == count_ff);

   // Configuration writes.
   always_comb begin
      cfg_rows_in = cfg_rows_ff;
      cfg_cols_in = cfg_cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            maga_pkg::REG_ROWS: cfg_rows_in = csr_wdata;
            maga_pkg::REG_COLS: cfg_cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next values of the window, count and walk registers.
   always_comb begin
      req_row_in_nx = req_row_ff;
      req_col_in_nx = req_col_ff;
      req_arg_in    = req_arg_ff;
      top_in        = top_ff;
      left_in       = left_ff;
      height_in     = height_ff;
      width_in      = width_ff;
      halted_in     = halted_ff;
      count_in      = count_ff;
      clr_cnt_in    = clr_cnt_ff;
      step_idx_in   = step_idx_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_head_in   = cur_head_ff;
      if (cmd_i.capture) begin
         req_row_in_nx = req_row_in;
         req_col_in_nx = req_col_in;
         req_arg_in    = req_arg;
      end
      if (cmd_i.init_win) begin
         height_in = rows_cl;
         width_in  = cols_cl;
         top_in    = init_top;
         left_in   = init_left;
         count_in  = '0;
         halted_in = 1'b0;
      end
      if (cmd_i.clr_step) begin
         clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
      end
      if (cmd_i.add_ant && add_ok) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd_i.step_first) begin
         step_idx_in = '0;
      end
      if (cmd_i.step_next) begin
         step_idx_in = step_idx_ff + 1'b1;
      end
      if (cmd_i.ant_load) begin
         cur_row_in  = ant_rd_ff.row;
         cur_col_in  = ant_rd_ff.col;
         cur_head_in = ant_rd_ff.head;
      end
      if (cmd_i.flip_move) begin
         if (move_ok) begin
            cur_row_in = new_row;
            cur_col_in = new_col;
            if (leave) begin
               case (cur_head_ff)
                  maga_pkg::HEAD_UP: begin
                     top_in    = CW'(LW'(top_ff) - LW'(height_ff));
                     height_in = maga_pkg::SIZE_W'(h_dbl);
                  end
                  maga_pkg::HEAD_DOWN: height_in = maga_pkg::SIZE_W'(h_dbl);
                  maga_pkg::HEAD_LEFT: begin
                     left_in  = CW'(LW'(left_ff) - LW'(width_ff));
                     width_in = maga_pkg::SIZE_W'(w_dbl);
                  end
                  maga_pkg::HEAD_RIGHT: width_in = maga_pkg::SIZE_W'(w_dbl);
                  default: ;
               endcase
            end
         end else begin
            halted_in = 1'b1;
         end
      end
      if (cmd_i.turn) begin
         cur_head_in = head_turned;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rows_ff <= maga_pkg::CFG_RESET;
         cfg_cols_ff <= maga_pkg::CFG_RESET;
         top_ff      <= '0;
         left_ff     <= '0;
         height_ff   <= maga_pkg::SIZE_W'(1);
         width_ff    <= maga_pkg::SIZE_W'(1);
         halted_ff   <= 1'b0;
         count_ff    <= '0;
         clr_cnt_ff  <= '0;
         step_idx_ff <= '0;
      end else begin
         cfg_rows_ff <= cfg_rows_in;
         cfg_cols_ff <= cfg_cols_in;
         top_ff      <= top_in;
         left_ff     <= left_in;
         height_ff   <= height_in;
         width_ff    <= width_in;
         halted_ff   <= halted_in;
         count_ff    <= count_in;
         clr_cnt_ff  <= clr_cnt_in;
         step_idx_ff <= step_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_row_ff  <= req_row_in_nx;
      req_col_ff  <= req_col_in_nx;
      req_arg_ff  <= req_arg_in;
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      cur_head_ff <= cur_head_in;
   end

   // Board write port: clearing pass, set cell, or the flip of the ant's cell.
   assign set_mask  = BOARD_SIDE'(1) << set_col_abs;
   assign flip_mask = BOARD_SIDE'(1) << cur_col_ff;
   always_comb begin
      board_we = 1'b0;
      board_wa = clr_cnt_ff;
      board_wd = '0;
      if (cmd_i.clr_step) begin
         board_we = 1'b1;
      end else if (cmd_i.set_wr) begin
         board_we = set_inside;
         board_wa = set_row_abs;
         board_wd = req_arg_ff[0] ? (board_rd_ff | set_mask) : (board_rd_ff & ~set_mask);
      end else if (cmd_i.flip_move) begin
         board_we = 1'b1;
         board_wa = cur_row_ff;
         board_wd = board_rd_ff ^ flip_mask;
      end
   end

   // Board read row address.
   always_comb begin
      case (cmd_i.rd_sel)
         maga_pkg::RD_ANT: board_ra = ant_rd_ff.row;
         maga_pkg::RD_CUR: board_ra = cur_row_ff;
         maga_pkg::RD_SET: board_ra = set_row_abs;
         default:          board_ra = cur_row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (board_we) begin
         board_mem[board_wa] <= board_wd;
      end
      if (cmd_i.board_rd) begin
         board_rd_ff <= board_mem[board_ra];
      end
   end

   // Ant table write port: a new ant, or the walked ant's new position and heading.
   always_comb begin
      if (cmd_i.turn) begin
         ant_we = 1'b1;
         ant_wa = step_idx_ff;
         ant_wd = '{row: cur_row_ff, col: cur_col_ff, head: head_turned};
      end else begin
         ant_we = cmd_i.add_ant && add_ok;
         ant_wa = count_ff[AW-1:0];
         ant_wd = '{row: set_row_abs, col: set_col_abs, head: req_arg_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ant_we) begin
         ant_mem[ant_wa] <= ant_wd;
      end
      if (cmd_i.ant_rd) begin
         ant_rd_ff <= ant_mem[step_idx_ff];
      end
   end

   // Response word for each kind of result.
   always_comb begin
      res_idx    = '0;
      res_row    = '0;
      res_col    = '0;
      res_head   = '0;
      res_status = maga_pkg::ST_OK;
      res_last   = 1'b1;
      case (cmd_i.out_kind)
         maga_pkg::KIND_INIT: ;
         maga_pkg::KIND_SET: begin
            res_row    = req_row_ff;
            res_col    = req_col_ff;
            res_status = set_inside ? maga_pkg::ST_OK : maga_pkg::ST_OUTSIDE;
         end
         maga_pkg::KIND_ADD: begin
            res_row  = req_row_ff;
            res_col  = req_col_ff;
            res_head = req_arg_ff;
            if (ant_full) begin
               res_status = maga_pkg::ST_FULL;
            end else if (!set_inside) begin
               res_status = maga_pkg::ST_OUTSIDE;
            end else begin
               res_idx = maga_pkg::IDX_W'(count_ff);
            end
         end
         maga_pkg::KIND_NONE: begin
            res_status = halted_ff ? maga_pkg::ST_HALT : maga_pkg::ST_OK;
         end
         maga_pkg::KIND_ANT: begin
            res_idx    = maga_pkg::IDX_W'(step_idx_ff);
            res_row    = maga_pkg::POS_W'(rel_row);
            res_col    = maga_pkg::POS_W'(rel_col);
            res_head   = cur_head_ff;
            res_status = halted_ff ? maga_pkg::ST_HALT : maga_pkg::ST_OK;
            res_last   = halted_ff || last_ant;
         end
         default: ;
      endcase
   end

   // Output register; a new word may load in the cycle the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load_out) begin
         out_idx_ff    <= res_idx;
         out_row_ff    <= res_row;
         out_col_ff    <= res_col;
         out_head_ff   <= res_head;
         out_wrows_ff  <= height_ff;
         out_wcols_ff  <= width_ff;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ant_index   = out_idx_ff;
   assign rsp_ant_row     = out_row_ff;
   assign rsp_ant_col     = out_col_ff;
   assign rsp_heading     = out_head_ff;
   assign rsp_window_rows = out_wrows_ff;
   assign rsp_window_cols = out_wcols_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   // Status back to the controller.
   assign sts_o.clr_last = clr_last;
   assign sts_o.out_free = !rsp_valid_ff || rsp_ready;
   assign sts_o.halted   = halted_ff;
   assign sts_o.no_ants  = (count_ff == '0);
   assign sts_o.last_ant = last_ant;

endmodule

// ===== hdl/maga_ctrl.sv =====
module maga_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [maga_pkg::CMD_W-1:0]  req_cmd,
   output logic                        req_ready,
   input  maga_pkg::ctl_sts_type       sts_i,
   output maga_pkg::ctl_cmd_type       cmd_o
);

   localparam logic [3:0] S_RCLR  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ICLR  = 4'd2;
   localparam logic [3:0] S_EMIT  = 4'd3;
   localparam logic [3:0] S_SRD   = 4'd4;
   localparam logic [3:0] S_SWR   = 4'd5;
   localparam logic [3:0] S_ADD   = 4'd6;
   localparam logic [3:0] S_ARD   = 4'd7;
   localparam logic [3:0] S_ALD   = 4'd8;
   localparam logic [3:0] S_FLIP  = 4'd9;
   localparam logic [3:0] S_NRD   = 4'd10;
   localparam logic [3:0] S_TURN  = 4'd11;
   localparam logic [3:0] S_AEMIT = 4'd12;

   logic [3:0]         state_ff, state_in;
   maga_pkg::kind_type kind_ff, kind_in;

   // Sequencing of one command at a time.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd_o     = '0;
      case (state_ff)
         S_RCLR: begin
            cmd_o.clr_step = 1'b1;
            if (sts_i.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.capture = 1'b1;
               case (req_cmd)
                  maga_pkg::CMD_INIT: begin
                     cmd_o.init_win = 1'b1;
                     kind_in        = maga_pkg::KIND_INIT;
                     state_in       = S_ICLR;
                  end
                  maga_pkg::CMD_SET: begin
                     kind_in  = maga_pkg::KIND_SET;
                     state_in = S_SRD;
                  end
                  maga_pkg::CMD_ADD: state_in = S_ADD;
                  maga_pkg::CMD_STEP: begin
                     if (sts_i.halted || sts_i.no_ants) begin
                        kind_in  = maga_pkg::KIND_NONE;
                        state_in = S_EMIT;
                     end else begin
                        cmd_o.step_first = 1'b1;
                        state_in         = S_ARD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ICLR: begin
            cmd_o.clr_step = 1'b1;
            if (sts_i.clr_last) begin
               state_in = S_EMIT;
            end
         end
         S_SRD: begin
            cmd_o.board_rd = 1'b1;
            cmd_o.rd_sel   = maga_pkg::RD_SET;
            state_in       = S_SWR;
         end
         S_SWR: begin
            cmd_o.set_wr = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (sts_i.out_free) begin
               cmd_o.load_out = 1'b1;
               cmd_o.out_kind = kind_ff;
               state_in       = S_IDLE;
            end
         end
         S_ADD: begin
            if (sts_i.out_free) begin
               cmd_o.add_ant  = 1'b1;
               cmd_o.load_out = 1'b1;
               cmd_o.out_kind = maga_pkg::KIND_ADD;
               state_in       = S_IDLE;
            end
         end
         S_ARD: begin
            cmd_o.ant_rd = 1'b1;
            state_in     = S_ALD;
         end
         S_ALD: begin
            cmd_o.ant_load = 1'b1;
            cmd_o.board_rd = 1'b1;
            cmd_o.rd_sel   = maga_pkg::RD_ANT;
            state_in       = S_FLIP;
         end
         S_FLIP: begin
            cmd_o.flip_move = 1'b1;
            state_in        = S_NRD;
         end
         S_NRD: begin
            // After an overflow the ant keeps its heading, so no read is needed.
            if (sts_i.halted) begin
               state_in = S_AEMIT;
            end else begin
               cmd_o.board_rd = 1'b1;
               cmd_o.rd_sel   = maga_pkg::RD_CUR;
               state_in       = S_TURN;
            end
         end
         S_TURN: begin
            cmd_o.turn = 1'b1;
            state_in   = S_AEMIT;
         end
         S_AEMIT: begin
            if (sts_i.out_free) begin
               cmd_o.load_out = 1'b1;
               cmd_o.out_kind = maga_pkg::KIND_ANT;
               if (sts_i.halted || sts_i.last_ant) begin
                  state_in = S_IDLE;
               end else begin
                  cmd_o.step_next = 1'b1;
                  state_in        = S_ARD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RCLR;
         kind_ff  <= maga_pkg::KIND_INIT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== hdl/multi_ant_grid_walker.sv =====
// Langton's-ant engine for up to MAX_ANTS ants on a BOARD_SIDE x BOARD_SIDE board.
// Request words arrive on req_ch (cmd, row_in, col_in, arg); result words leave on
// rsp_ch. The csr_ port writes initial_rows (index 0) and initial_cols (index 1),
// which the init command uses to size and centre the window.
// One command is worked at a time; req_ch.ready is high only between commands.
// Work for each command before its first result word is loaded:
//   init      the board is cleared one row per cycle,
//   set cell  read, modify and write of one board row,
//   add ant   an accepted ant is written to the table as its result word loads,
//   step      per ant: ant table read, board row read, flip and move,
//             new row read, turn, result; one result word per ant.
// A step with no ants or while halted gives one word; an overflow ends the walk.
// After reset the block runs a clearing pass over every board row before it
// accepts the first word; csr writes are taken during it.
// Results sit in an output register. When the receiver stalls the block holds
// that word and waits before it loads the next one; the walk resumes once the
// word is taken.
`include "assert_macros.svh"

module multi_ant_grid_walker #(
   parameter int BOARD_SIDE = 256,
   parameter int MAX_ANTS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   maga_req_if.sink                        req_ch,
   maga_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [maga_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [maga_pkg::SIZE_W-1:0]     csr_wdata
);

   maga_pkg::ctl_cmd_type dp_cmd;
   maga_pkg::ctl_sts_type dp_sts;
   logic                  req_ready;

   // Command sequencer.
   maga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ready),
      .sts_i     (dp_sts),
      .cmd_o     (dp_cmd)
   );

   assign req_ch.ready = req_ready;

   // Board, ant table, window registers and output register.
   maga_datapath #(
      .BOARD_SIDE (BOARD_SIDE),
      .MAX_ANTS   (MAX_ANTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_row_in      (req_ch.row_in),
      .req_col_in      (req_ch.col_in),
      .req_arg         (req_ch.arg),
      .cmd_i           (dp_cmd),
      .sts_o           (dp_sts),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ant_index   (rsp_ch.ant_index),
      .rsp_ant_row     (rsp_ch.ant_row),
      .rsp_ant_col     (rsp_ch.ant_col),
      .rsp_heading     (rsp_ch.heading),
      .rsp_window_rows (rsp_ch.window_rows),
      .rsp_window_cols (rsp_ch.window_cols),
      .rsp_status      (rsp_ch.status),
      .rsp_last        (rsp_ch.last)
   );

   // A result word is never loaded over one that is still waiting.
   `MAGA_ASSERT_IMPLY(a_load_free, clock, reset, dp_cmd.load_out, dp_sts.out_free, "result word overwritten")
   // Only one source drives the board write port at a time.
   `MAGA_ASSERT_ALWAYS(a_one_writer, clock, reset, $countones({dp_cmd.clr_step, dp_cmd.set_wr, dp_cmd.flip_move}) <= 1, "board write conflict")
   // While a new word can be taken no command is still at work.
   `MAGA_ASSERT_IMPLY(a_idle_quiet, clock, reset, req_ready, !dp_cmd.load_out && !dp_cmd.clr_step && !dp_cmd.flip_move, "work while ready")
   // An ant that hit the window limit is not turned.
   `MAGA_ASSERT_IMPLY(a_no_turn_halt, clock, reset, dp_cmd.turn, !dp_sts.halted, "turn after overflow")

endmodule

// ===== test/multi_ant_grid_walker_test.sv =====
module multi_ant_grid_walker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import maga_pkg::*;

   localparam int BOARD_SIDE  = 256;
   localparam int MAX_ANTS    = 16;
   localparam int WIN_LIMIT   = (BOARD_SIDE < 256) ? BOARD_SIDE : 256;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [ARG_W-1:0] arg;
   } walk_cmd_t;

   typedef struct packed {
      logic [IDX_W-1:0]    ant;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
      logic [1:0]          head;
      logic [SIZE_W-1:0]   rows;
      logic [SIZE_W-1:0]   cols;
      logic [STATUS_W-1:0] status;
      logic                last;
   } walk_report_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   maga_req_if req_ch ();
   maga_rsp_if rsp_ch ();

   multi_ant_grid_walker uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Stimulus and scoreboard storage.
   walk_cmd_t    pending_cmds [$];
   walk_report_t expected_reports [$];
   walk_cmd_t    offered_cmd;
   int           sender_idle_pct;
   int           receiver_idle_pct;
   int           mismatch_count;
   int           quiet_cycles;

   // Predicted state of the walker.
   logic [BOARD_SIDE-1:0] board [BOARD_SIDE];
   int                    ant_row_abs [MAX_ANTS];
   int                    ant_col_abs [MAX_ANTS];
   logic [1:0]            ant_head [MAX_ANTS];
   int                    ant_count;
   int                    win_top;
   int                    win_left;
   int                    win_h;
   int                    win_w;
   bit                    walk_halted;
   logic [SIZE_W-1:0]     init_rows_cfg;
   logic [SIZE_W-1:0]     init_cols_cfg;

   // Window size that init derives from a register value.
   function automatic int clamped_span(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > WIN_LIMIT) return WIN_LIMIT;
      return int'(v);
   endfunction

   task automatic reset_walker_model();
      foreach (board[r]) board[r] = '0;
      ant_count     = 0;
      win_top       = 0;
      win_left      = 0;
      win_h         = 1;
      win_w         = 1;
      walk_halted   = 1'b0;
      init_rows_cfg = CFG_RESET;
      init_cols_cfg = CFG_RESET;
   endtask

   task automatic expect_report(int ant, int row, int col, logic [1:0] head,
                                logic [STATUS_W-1:0] status, bit last);
      walk_report_t rep;
      rep.ant    = IDX_W'(ant);
      rep.row    = POS_W'(row);
      rep.col    = POS_W'(col);
      rep.head   = head;
      rep.rows   = SIZE_W'(win_h);
      rep.cols   = SIZE_W'(win_w);
      rep.status = status;
      rep.last   = last;
      expected_reports.push_back(rep);
   endtask

   // Apply one accepted command to the predicted state and queue its reports.
   task automatic advance_walker(walk_cmd_t w);
      int         r;
      int         c;
      int         nr;
      int         nc;
      int         i;
      bit         grew_ok;
      logic [1:0] h;
      case (w.cmd)
         CMD_INIT: begin
            foreach (board[k]) board[k] = '0;
            ant_count   = 0;
            walk_halted = 1'b0;
            win_h       = clamped_span(init_rows_cfg);
            win_w       = clamped_span(init_cols_cfg);
            win_top     = (BOARD_SIDE - win_h) / 2;
            win_left    = (BOARD_SIDE - win_w) / 2;
            expect_report(0, 0, 0, HEAD_UP, ST_OK, 1'b1);
         end
         CMD_SET: begin
            if (w.row >= win_h || w.col >= win_w) begin
               expect_report(0, w.row, w.col, HEAD_UP, ST_OUTSIDE, 1'b1);
            end else begin
               board[win_top + w.row][win_left + w.col] = w.arg[0];
               expect_report(0, w.row, w.col, HEAD_UP, ST_OK, 1'b1);
            end
         end
         CMD_ADD: begin
            if (ant_count >= MAX_ANTS) begin
               expect_report(0, w.row, w.col, w.arg, ST_FULL, 1'b1);
            end else if (w.row >= win_h || w.col >= win_w) begin
               expect_report(0, w.row, w.col, w.arg, ST_OUTSIDE, 1'b1);
            end else begin
               ant_row_abs[ant_count] = win_top + w.row;
               ant_col_abs[ant_count] = win_left + w.col;
               ant_head[ant_count]    = w.arg;
               expect_report(ant_count, w.row, w.col, w.arg, ST_OK, 1'b1);
               ant_count++;
            end
         end
         default: begin
            if (walk_halted) begin
               expect_report(0, 0, 0, HEAD_UP, ST_HALT, 1'b1);
               return;
            end
            if (ant_count == 0) begin
               expect_report(0, 0, 0, HEAD_UP, ST_OK, 1'b1);
               return;
            end
            for (i = 0; i < ant_count; i++) begin
               r  = ant_row_abs[i];
               c  = ant_col_abs[i];
               h  = ant_head[i];
               nr = r;
               nc = c;
               case (h)
                  HEAD_UP:    nr = r - 1;
                  HEAD_RIGHT: nc = c + 1;
                  HEAD_DOWN:  nr = r + 1;
                  default:    nc = c - 1;
               endcase
               board[r][c] = ~board[r][c];
               // The window doubles toward the side the ant left by, if it can.
               grew_ok = 1'b1;
               if (nr < win_top) begin
                  if (win_top >= win_h && 2 * win_h <= WIN_LIMIT) begin
                     win_top = win_top - win_h;
                     win_h   = 2 * win_h;
                  end else begin
                     grew_ok = 1'b0;
                  end
               end else if (nr >= win_top + win_h) begin
                  if (win_top + 2 * win_h <= BOARD_SIDE && 2 * win_h <= WIN_LIMIT) begin
                     win_h = 2 * win_h;
                  end else begin
                     grew_ok = 1'b0;
                  end
               end else if (nc < win_left) begin
                  if (win_left >= win_w && 2 * win_w <= WIN_LIMIT) begin
                     win_left = win_left - win_w;
                     win_w    = 2 * win_w;
                  end else begin
                     grew_ok = 1'b0;
                  end
               end else if (nc >= win_left + win_w) begin
                  if (win_left + 2 * win_w <= BOARD_SIDE && 2 * win_w <= WIN_LIMIT) begin
                     win_w = 2 * win_w;
                  end else begin
                     grew_ok = 1'b0;
                  end
               end
               // An overflow stops the walk; the ant stays where it was.
               if (!grew_ok) begin
                  walk_halted = 1'b1;
                  expect_report(i, r - win_top, c - win_left, h, ST_HALT, 1'b1);
                  return;
               end
               ant_row_abs[i] = nr;
               ant_col_abs[i] = nc;
               h = board[nr][nc] ? h + TURN_LEFT : h + TURN_RIGHT;
               ant_head[i] = h;
               expect_report(i, nr - win_top, nc - win_left, h, ST_OK, i + 1 == ant_count);
            end
         end
      endcase
   endtask

   function automatic void compare_field(string name, logic [SIZE_W-1:0] want,
                                         logic [SIZE_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_report();
      walk_report_t want;
      if (expected_reports.size() == 0) begin
         $error("result word with no command pending: ant %0d row %0d col %0d status %0d",
                rsp_ch.ant_index, rsp_ch.ant_row, rsp_ch.ant_col, rsp_ch.status);
         mismatch_count++;
         return;
      end
      want = expected_reports.pop_front();
      compare_field("ant_index",   want.ant,    rsp_ch.ant_index);
      compare_field("ant_row",     want.row,    rsp_ch.ant_row);
      compare_field("ant_col",     want.col,    rsp_ch.ant_col);
      compare_field("heading",     want.head,   rsp_ch.heading);
      compare_field("window_rows", want.rows,   rsp_ch.window_rows);
      compare_field("window_cols", want.cols,   rsp_ch.window_cols);
      compare_field("status",      want.status, rsp_ch.status);
      compare_field("last",        want.last,   rsp_ch.last);
   endtask

   // Request driver: holds a word until it is taken, then predicts it.
   always @(posedge clock) begin
      bit holding;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         holding = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            advance_walker(offered_cmd);
         end
         if (!holding) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_cmd    = pending_cmds.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.cmd    <= offered_cmd.cmd;
               req_ch.row_in <= offered_cmd.row;
               req_ch.col_in <= offered_cmd.col;
               req_ch.arg    <= offered_cmd.arg;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_report();
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog on cycles where no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                             logic [POS_W-1:0] col, logic [ARG_W-1:0] arg);
      walk_cmd_t w;
      w.cmd = cmd;
      w.row = row;
      w.col = col;
      w.arg = arg;
      pending_cmds.push_back(w);
   endtask

   // Block until every queued word is taken and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_ch.valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= REG_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      init_rows_cfg = rows;
      init_cols_cfg = cols;
   endtask

   // Edge cases on the reset window, a full ant table, overflow and halt.
   task automatic queue_directed_words();
      logic [1:0] pattern [4] = '{HEAD_DOWN, HEAD_RIGHT, HEAD_UP, HEAD_LEFT};
      int         i;
      queue_word(CMD_SET, 8'd1, 8'd0, 2'd1);
      queue_word(CMD_SET, 8'd0, 8'd0, 2'd3);
      queue_word(CMD_STEP, 8'd0, 8'd0, 2'd0);
      queue_word(CMD_ADD, 8'd0, 8'd1, HEAD_RIGHT);
      for (i = 0; i < MAX_ANTS; i++) queue_word(CMD_ADD, 8'd0, 8'd0, pattern[i % 4]);
      queue_word(CMD_ADD, 8'd255, 8'd255, HEAD_LEFT);
      queue_word(CMD_STEP, 8'd255, 8'd255, 2'd3);
      queue_word(CMD_STEP, 8'd0, 8'd0, 2'd0);
      queue_word(CMD_INIT, 8'd255, 8'd255, 2'd3);
      queue_word(CMD_ADD, 8'd15, 8'd15, HEAD_LEFT);
      queue_word(CMD_ADD, 8'd16, 8'd0, HEAD_UP);
      queue_word(CMD_STEP, 8'd0, 8'd0, 2'd0);
      queue_word(CMD_SET, 8'd255, 8'd255, 2'd0);
   endtask

   // One walk: init, some painted cells, a few ants or now and then more than the
   // table holds, then mostly steps with some stray words mixed in.
   task automatic queue_random_phase(int budget);
      int used;
      int new_ants;
      int rows_eff;
      int cols_eff;
      int roll;
      rows_eff = clamped_span(init_rows_cfg);
      cols_eff = clamped_span(init_cols_cfg);
      queue_word(CMD_INIT, $urandom, $urandom, $urandom);
      used = 1;
      repeat ($urandom_range(3)) begin
         queue_word(CMD_SET, $urandom_range(rows_eff - 1), $urandom_range(cols_eff - 1),
                    $urandom);
         used++;
      end
      new_ants = ($urandom_range(7) == 0) ? MAX_ANTS + 1 : $urandom_range(1, 6);
      repeat (new_ants) begin
         queue_word(CMD_ADD, $urandom_range(rows_eff - 1), $urandom_range(cols_eff - 1),
                    $urandom);
         used++;
      end
      while (used < budget) begin
         roll = $urandom_range(99);
         if (roll < 72) begin
            queue_word(CMD_STEP, $urandom, $urandom, $urandom);
         end else if (roll < 80) begin
            queue_word(CMD_SET, $urandom_range(rows_eff - 1), $urandom_range(cols_eff - 1),
                       $urandom);
         end else if (roll < 86) begin
            queue_word(CMD_ADD, $urandom_range(rows_eff - 1), $urandom_range(cols_eff - 1),
                       $urandom);
         end else begin
            queue_word($urandom, $urandom, $urandom, $urandom);
         end
         used++;
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] rows_plan [8];
      logic [SIZE_W-1:0] cols_plan [8];
      int                phase;
      rows_plan = '{9'd16, 9'd1, 9'd256, 9'd0, 9'd3, 9'd511, 9'd0, 9'd2};
      cols_plan = '{9'd16, 9'd1, 9'd256, 9'd511, 9'd200, 9'd0, 9'd0, 9'd256};
      rows_plan[6] = SIZE_W'($urandom_range(1, 48));
      cols_plan[6] = SIZE_W'($urandom_range(1, 48));
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_ROWS;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_INIT;
      req_ch.row_in     = '0;
      req_ch.col_in     = '0;
      req_ch.arg        = '0;
      rsp_ch.ready      = 1'b0;
      mismatch_count    = 0;
      quiet_cycles      = 0;
      sender_idle_pct   = 20;
      receiver_idle_pct = 74;
      reset_walker_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_directed_words();
      for (phase = 0; phase < 8; phase++) begin
         if (phase != 0) begin
            wait_drained();
            if (phase == 3) begin
               sender_idle_pct   = 74;
               receiver_idle_pct = 20;
            end else if (phase == 6) begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
            write_sizes(rows_plan[phase], cols_plan[phase]);
         end
         queue_random_phase(30);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
